// File: sv/sls_pkg.sv
// Shared constants, command codes and helpers for the searchable LIFO stack.
// Used by the stack controller; depends on nothing else.
package sls_pkg;

  localparam int DEPTH  = 256;
  localparam int DATA_W = 32;
  localparam int CMD_W  = 3;
  localparam int POS_W  = 9;
  localparam int LEN_W  = 9;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH   = 3'd0,
    CMD_POP    = 3'd1,
    CMD_READ   = 3'd2,
    CMD_SEARCH = 3'd3,
    CMD_CLEAR  = 3'd4
  } cmd_t;

  typedef logic [CNT_W-1:0] cnt_t;

  function automatic logic [LEN_W-1:0] len_field(input cnt_t value);
    logic [CMP_W-1:0] wide;
    wide = CMP_W'(value);
    return wide[LEN_W-1:0];
  endfunction

endpackage

// File: sv/searchable_lifo_stack.sv
// Path from request to result: push, clear, bad commands and refused pop, read or search
// go from idle straight to the done state; pop and read pass a RAM read state first, and
// search a search state that probes entries from the top (at most DEPTH of them).
// One request is worked at a time; search throughput is set by one RAM read per cycle.
// A new request is taken while a finished result still waits at the output register.
// Reset clears the entry count and output valid; the entry RAM is not cleared.
module searchable_lifo_stack (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                req_valid,
  output logic                                req_stall,
  input  logic [sls_pkg::CMD_W-1:0]           command,
  input  logic signed [sls_pkg::DATA_W-1:0]   data_value,
  input  logic [sls_pkg::POS_W-1:0]           position,
  output logic                                rsp_valid,
  input  logic                                rsp_stall,
  output logic                                success,
  output logic signed [sls_pkg::DATA_W-1:0]   result_value,
  output logic [sls_pkg::LEN_W-1:0]           found_position,
  output logic [sls_pkg::LEN_W-1:0]           stack_length,
  output logic                                is_empty
);

  import sls_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_READ   = 4'b0010,
    S_SEARCH = 4'b0100,
    S_DONE   = 4'b1000
  } state_t;

  state_t              state;
  cnt_t                count;
  cnt_t                probe;
  logic [ADDR_W-1:0]   search_addr;
  logic [DATA_W-1:0]   key;
  logic                res_success;
  logic [DATA_W-1:0]   res_value;
  cnt_t                res_found;

  logic                accept;
  logic                out_free;
  logic [CMP_W-1:0]    pos_ext;
  logic [CMP_W-1:0]    cnt_ext;
  logic                pos_ok;
  logic                not_full;
  logic                match;
  logic                ram_we;
  logic                ram_re;
  logic [ADDR_W-1:0]   ram_raddr;
  logic [DATA_W-1:0]   ram_rdata;

  assign req_stall = (state != S_IDLE);
  assign accept    = req_valid && (state == S_IDLE);
  assign out_free  = !rsp_valid || !rsp_stall;
  assign pos_ext   = CMP_W'(position);
  assign cnt_ext   = CMP_W'(count);
  assign pos_ok    = (pos_ext != '0) && (pos_ext <= cnt_ext);
  assign not_full  = (count < CNT_W'(DEPTH));
  assign match     = (ram_rdata == key);
  assign ram_we    = accept && (command == CMD_PUSH) && not_full;

  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = ADDR_W'(count - 1'b1);
    priority if (accept) begin
      priority if (command == CMD_POP || command == CMD_SEARCH) begin
        ram_re = (count != '0);
      end else if (command == CMD_READ) begin
        ram_re    = pos_ok;
        ram_raddr = ADDR_W'(cnt_ext - pos_ext);
      end else begin
        ram_re = 1'b0;
      end
    end else if (state == S_SEARCH && !match && probe != count) begin
      ram_re    = 1'b1;
      ram_raddr = search_addr - 1'b1;
    end else begin
      ram_re = 1'b0;
    end
  end

  sls_ram #(
    .DATA_W (DATA_W),
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count[ADDR_W-1:0]),
    .wdata (data_value),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (state == S_DONE && out_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            res_found   <= '0;
            res_value   <= '0;
            res_success <= 1'b0;
            key         <= data_value;
            state       <= S_DONE;
            unique case (command)
              CMD_PUSH: begin
                res_success <= not_full;
                if (not_full) begin
                  count <= count + 1'b1;
                end
              end
              CMD_POP: begin
                if (count != '0) begin
                  count       <= count - 1'b1;
                  res_success <= 1'b1;
                  state       <= S_READ;
                end
              end
              CMD_READ: begin
                if (pos_ok) begin
                  res_success <= 1'b1;
                  state       <= S_READ;
                end
              end
              CMD_SEARCH: begin
                if (count != '0) begin
                  probe       <= CNT_W'(1);
                  search_addr <= ADDR_W'(count - 1'b1);
                  state       <= S_SEARCH;
                end
              end
              CMD_CLEAR: begin
                count       <= '0;
                res_success <= 1'b1;
              end
              default: begin
                res_success <= 1'b0;
              end
            endcase
          end
        end
        S_READ: begin
          res_value <= ram_rdata;
          state     <= S_DONE;
        end
        S_SEARCH: begin
          priority if (match) begin
            res_success <= 1'b1;
            res_found   <= probe;
            state       <= S_DONE;
          end else if (probe == count) begin
            state <= S_DONE;
          end else begin
            probe       <= probe + 1'b1;
            search_addr <= search_addr - 1'b1;
          end
        end
        S_DONE: begin
          if (out_free) begin
            success        <= res_success;
            result_value   <= res_value;
            found_position <= len_field(res_found);
            stack_length   <= len_field(count);
            is_empty       <= (count == '0);
            state          <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("entry count exceeds depth");

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    ram_we |=> count == $past(count) + 1'b1)
    else $error("accepted push did not grow the stack");

  a_write_idle: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> state == S_IDLE)
    else $error("RAM write outside idle");

  a_probe_range: assert property (@(posedge clk) disable iff (rst)
    state == S_SEARCH |-> (probe != '0) && (probe <= count))
    else $error("search probe out of range");

  a_empty_len: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && out_free) |=> is_empty == (stack_length == '0))
    else $error("empty flag disagrees with length");

endmodule

// File: sv/sls_ram.sv
// Generic single-port-write, single-port-read synchronous RAM with registered read data.
// Stand-alone; no package dependency.
module sls_ram #(
  parameter int DATA_W = 32,
  parameter int DEPTH  = 256,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
